FILE: sv/athm_pkg.sv
// shared types, constants and the degree arctangent table for the tilt monitor
package athm_pkg;

   // item modes
   localparam logic [1:0] MODE_CAL   = 2'd0;
   localparam logic [1:0] MODE_CLOSE = 2'd1;
   localparam logic [1:0] MODE_MEAS  = 2'd2;
   localparam logic [1:0] MODE_ERR   = 2'd3;

   // register indexes
   localparam logic [1:0] REG_SHIFT = 2'd0;
   localparam logic [1:0] REG_ON    = 2'd1;
   localparam logic [1:0] REG_OFF   = 2'd2;

   // angle fraction bits, tied to the 17-bit angle type
   localparam int ANGLE_FRAC_BITS = 8;

   localparam int CORDIC_STEPS = 18;
   localparam int TABLE_FRAC   = 16;
   localparam int STEP_W       = 5;
   localparam int ROOT_W       = 31;   // root of up to 2^59
   localparam int RAD_W        = 60;   // radicand bits
   localparam int CX_W         = 34;   // cordic x, y width
   localparam int CZ_W         = 24;   // cordic angle accumulator

   typedef logic signed [16:0] angle_type;

   function automatic logic signed [CZ_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
      logic signed [CZ_W-1:0] v;
      unique case (i)
         5'd0:  v = 24'sd2949120;
         5'd1:  v = 24'sd1740967;
         5'd2:  v = 24'sd919879;
         5'd3:  v = 24'sd466945;
         5'd4:  v = 24'sd234379;
         5'd5:  v = 24'sd117304;
         5'd6:  v = 24'sd58666;
         5'd7:  v = 24'sd29335;
         5'd8:  v = 24'sd14668;
         5'd9:  v = 24'sd7334;
         5'd10: v = 24'sd3667;
         5'd11: v = 24'sd1833;
         5'd12: v = 24'sd917;
         5'd13: v = 24'sd458;
         5'd14: v = 24'sd229;
         5'd15: v = 24'sd115;
         5'd16: v = 24'sd57;
         5'd17: v = 24'sd29;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: sv/athm_lane.sv
// one tilt lane: square sums, bit-serial root, then cordic vectoring in degrees
module athm_lane (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [15:0]      axis_a,
   input  logic signed [15:0]      axis_b,
   input  logic signed [15:0]      axis_c,
   output logic                    done,
   output athm_pkg::angle_type     angle
);
   import athm_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQB  = 3'd1;
   localparam logic [2:0] ST_SQC  = 3'd2;
   localparam logic [2:0] ST_ROOT = 3'd3;
   localparam logic [2:0] ST_CORD = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;
   localparam int RSH = TABLE_FRAC - ANGLE_FRAC_BITS;
   localparam int LIM = 90 << ANGLE_FRAC_BITS;

   logic [2:0]                 state_ff, state_in;
   logic [STEP_W-1:0]          cnt_ff, cnt_in;
   logic signed [15:0]         a_ff, a_in, c_ff, c_in;
   logic [31:0]                sq_ff, sq_in;       // one square, registered
   logic [RAD_W-1:0]           rad_ff, rad_in;
   logic [ROOT_W+1:0]          rem_ff, rem_in;
   logic [ROOT_W-1:0]          root_ff, root_in;
   logic signed [CX_W-1:0]     x_ff, x_in, y_ff, y_in;
   logic signed [CZ_W-1:0]     z_ff, z_in;
   angle_type                  angle_ff, angle_in;

   // root and cordic step helpers
   logic [ROOT_W+1:0]          trial, rem_sh;
   logic signed [CX_W-1:0]     xs, ys;
   logic signed [CZ_W-1:0]     zabs, zr, zr_s;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      a_in     = a_ff;
      c_in     = c_ff;
      sq_in    = sq_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      angle_in = angle_ff;
      rem_sh   = {rem_ff[ROOT_W-1:0], rad_ff[RAD_W-1 -: 2]};
      trial    = {root_ff, 2'b01};
      xs       = x_ff >>> cnt_ff;
      ys       = y_ff >>> cnt_ff;
      zabs     = z_ff < 0 ? -z_ff : z_ff;
      zr       = (zabs + CZ_W'(1 << (RSH - 1))) >>> RSH;
      zr_s     = z_ff < 0 ? -zr : zr;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               a_in     = axis_a;
               c_in     = axis_c;
               sq_in    = 32'($signed(axis_b) * $signed(axis_b));
               state_in = ST_SQB;
            end
         end
         ST_SQB: begin
            rad_in   = RAD_W'(sq_ff);
            sq_in    = 32'($signed(c_ff) * $signed(c_ff));
            state_in = ST_SQC;
         end
         ST_SQC: begin
            // radicand = (b^2 + c^2) << 28
            rad_in   = (rad_ff + RAD_W'(sq_ff)) << 28;
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            // one root bit a cycle, restoring
            rad_in = rad_ff << 2;
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(RAD_W / 2 - 1)) begin
               state_in = ST_CORD;
               cnt_in   = '0;
               x_in     = CX_W'({1'b0, root_in});
               y_in     = CX_W'($signed(a_ff)) <<< 14;
               z_in     = '0;
            end
         end
         ST_CORD: begin
            if (y_ff > 0) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + atan_entry(cnt_ff);
            end else if (y_ff < 0) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - atan_entry(cnt_ff);
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(CORDIC_STEPS - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (zr_s > CZ_W'(LIM))       angle_in = 17'(LIM);
            else if (zr_s < -CZ_W'(LIM)) angle_in = -17'(LIM);
            else                         angle_in = 17'(zr_s);
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff   <= cnt_in;
      a_ff     <= a_in;
      c_ff     <= c_in;
      sq_ff    <= sq_in;
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      angle_ff <= angle_in;
   end

   // done pulses in the same cycle that the angle lands
   logic done_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= (state_ff == ST_DONE);
      end
   end

   assign done  = done_ff;
   assign angle = angle_ff;
endmodule

FILE: sv/athm_merge.sv
// merge stage: calibration sums, zero mean by serial divide, filter and alarm
module athm_merge #(
   parameter int MAX_CAL_SAMPLES = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    go,          // beat accepted
   input  logic [1:0]              mode,
   input  logic                    lanes_done,
   input  athm_pkg::angle_type     ang_x,
   input  athm_pkg::angle_type     ang_y,
   input  athm_pkg::angle_type     ang_z,
   input  logic [3:0]              cfg_shift,
   input  logic [7:0]              cfg_on,
   input  logic [7:0]              cfg_off,
   output logic                    fin,         // work done, result valid if has_rsp
   output logic                    has_rsp,
   output athm_pkg::angle_type     filt_x,
   output athm_pkg::angle_type     filt_y,
   output athm_pkg::angle_type     filt_z,
   output logic                    alarm
);
   import athm_pkg::*;

   localparam int CNT_W  = $clog2(MAX_CAL_SAMPLES + 1);
   localparam int SUM_W  = 24;
   localparam int HALF   = 180 << ANGLE_FRAC_BITS;

   localparam logic [2:0] M_IDLE = 3'd0;
   localparam logic [2:0] M_WAIT = 3'd1;
   localparam logic [2:0] M_DIV  = 3'd2;
   localparam logic [2:0] M_ALRM = 3'd3;
   localparam logic [2:0] M_FIN  = 3'd4;

   logic [2:0]             st_ff, st_in;
   logic [1:0]             mode_ff, mode_in;
   angle_type              zero_ff [3], zero_in [3];
   angle_type              filt_ff [3], filt_in [3];
   logic signed [SUM_W-1:0] sum_ff [3], sum_in [3];
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   seeded_ff, seeded_in, alarm_ff, alarm_in;
   logic [1:0]             ax_ff, ax_in;        // axis under division
   logic [4:0]             bit_ff, bit_in;
   logic [SUM_W-1:0]       num_ff, num_in, quo_ff, quo_in;
   logic [SUM_W:0]         rem_ff, rem_in, rem_sh;
   logic [16:0]            maxabs;
   logic [3:0]             sh;
   angle_type              a_in [3];
   logic signed [18:0]     d, e, ea, er;
   logic signed [SUM_W-1:0] v;
   logic [SUM_W-1:0]       vabs;
   logic [16:0]            fa [3];

   always_comb begin
      a_in[0] = ang_x;
      a_in[1] = ang_y;
      a_in[2] = ang_z;
      sh = cfg_shift > 4'd8 ? 4'd8 : cfg_shift;
      st_in = st_ff; mode_in = mode_ff; cnt_in = cnt_ff;
      seeded_in = seeded_ff; alarm_in = alarm_ff;
      ax_in = ax_ff; bit_in = bit_ff; num_in = num_ff; quo_in = quo_ff; rem_in = rem_ff;
      zero_in = zero_ff; filt_in = filt_ff; sum_in = sum_ff;
      d = '0; e = '0; ea = '0; er = '0;
      v = sum_ff[ax_ff];
      vabs = v < 0 ? SUM_W'(-v) : SUM_W'(v);
      rem_sh = {rem_ff[SUM_W-1:0], num_ff[SUM_W-1]};
      for (int i = 0; i < 3; i++) fa[i] = filt_ff[i] < 0 ? 17'(-filt_ff[i]) : 17'(filt_ff[i]);
      maxabs = fa[0];
      if (fa[1] > maxabs) maxabs = fa[1];
      if (fa[2] > maxabs) maxabs = fa[2];
      unique case (st_ff)
         M_IDLE: begin
            if (go) begin
               mode_in = mode;
               unique case (mode)
                  MODE_CAL: st_in = M_WAIT;
                  MODE_MEAS: st_in = M_WAIT;
                  MODE_CLOSE: begin
                     ax_in = '0; bit_in = '0; rem_in = '0; quo_in = '0;
                     num_in = '0; st_in = M_DIV;
                  end
                  MODE_ERR: st_in = M_FIN;
                  default: st_in = M_FIN;
               endcase
            end
         end
         M_WAIT: begin
            if (lanes_done) begin
               if (mode_ff == MODE_CAL) begin
                  // lanes always run; a full sum ignores the sample
                  if (cnt_ff < CNT_W'(MAX_CAL_SAMPLES)) begin
                     for (int i = 0; i < 3; i++) sum_in[i] = sum_ff[i] + SUM_W'(a_in[i]);
                     cnt_in = cnt_ff + 1'b1;
                  end
                  st_in = M_FIN;
               end else begin
                  for (int i = 0; i < 3; i++) begin
                     d = 19'(a_in[i]) - 19'(zero_ff[i]);
                     if (d > 19'(HALF)) d = d - 19'(2 * HALF);
                     else if (d < -19'(HALF)) d = d + 19'(2 * HALF);
                     if (seeded_ff) begin
                        e = d - 19'(filt_ff[i]);
                        ea = e < 0 ? -e : e;
                        if (sh != 4'd0) ea = (ea + (19'sd1 <<< (sh - 1'b1))) >>> sh;
                        er = e < 0 ? -ea : ea;
                        filt_in[i] = 17'(19'(filt_ff[i]) + er);
                     end else begin
                        filt_in[i] = 17'(d);
                     end
                  end
                  seeded_in = 1'b1;
                  st_in = M_ALRM;
               end
            end
         end
         M_DIV: begin
            // restoring divide of |sum| + count/2 by count, one bit a cycle
            if (bit_ff == 5'd0 && rem_ff == '0 && quo_ff == '0 && num_ff == '0) begin
               num_in = vabs + SUM_W'(cnt_ff >> 1);
               bit_in = 5'd1;
            end else begin
               num_in = num_ff << 1;
               if (rem_sh >= (SUM_W + 1)'(cnt_ff)) begin
                  rem_in = rem_sh - (SUM_W + 1)'(cnt_ff);
                  quo_in = {quo_ff[SUM_W-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  quo_in = {quo_ff[SUM_W-2:0], 1'b0};
               end
               bit_in = bit_ff + 1'b1;
               if (bit_ff == 5'(SUM_W)) begin
                  if (cnt_ff == '0) zero_in[ax_ff] = '0;
                  else zero_in[ax_ff] = v < 0 ? -17'(quo_in) : 17'(quo_in);
                  rem_in = '0; quo_in = '0; num_in = '0; bit_in = '0;
                  if (ax_ff == 2'd2) begin
                     for (int i = 0; i < 3; i++) begin
                        sum_in[i] = '0; filt_in[i] = '0;
                     end
                     cnt_in = '0; seeded_in = 1'b0; alarm_in = 1'b0;
                     st_in = M_FIN;
                  end else begin
                     ax_in = ax_ff + 1'b1;
                  end
               end
            end
         end
         M_ALRM: begin
            if (!alarm_ff && maxabs >= (17'(cfg_on) << ANGLE_FRAC_BITS)) alarm_in = 1'b1;
            else if (alarm_ff && maxabs <= (17'(cfg_off) << ANGLE_FRAC_BITS)) alarm_in = 1'b0;
            st_in = M_FIN;
         end
         M_FIN: st_in = M_IDLE;
         default: st_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= M_IDLE;
         cnt_ff <= '0; seeded_ff <= 1'b0; alarm_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            zero_ff[i] <= '0; filt_ff[i] <= '0; sum_ff[i] <= '0;
         end
      end else begin
         st_ff <= st_in;
         cnt_ff <= cnt_in; seeded_ff <= seeded_in; alarm_ff <= alarm_in;
         zero_ff <= zero_in; filt_ff <= filt_in; sum_ff <= sum_in;
      end
      mode_ff <= mode_in; ax_ff <= ax_in; bit_ff <= bit_in;
      num_ff <= num_in; quo_ff <= quo_in; rem_ff <= rem_in;
   end

   assign fin     = (st_ff == M_FIN);
   assign has_rsp = (mode_ff == MODE_MEAS) || (mode_ff == MODE_ERR);
   assign filt_x  = filt_ff[0];
   assign filt_y  = filt_ff[1];
   assign filt_z  = filt_ff[2];
   assign alarm   = alarm_ff;
endmodule

FILE: sv/accel_tilt_hysteresis_monitor.sv
// top level of the accelerometer tilt monitor: lanes, merge stage, output register
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/req_stall | mode, accel_x/y/z
//  rsp_    | out       | rsp_valid/rsp_stall | tilt, whole, alarm_on, sensor_error
//  csr_    | in        | csr_valid/csr_ready | csr_index, csr_data
// a sample runs from accept to result through two squares, 30 root bits, 18
// cordic steps, rounding and done per lane, lanes running together,
// then filter, alarm and finish; a calibration sample skips the alarm step
// a close runs the shared serial divider once per axis, then a finish step
// reset is synchronous and sets control, calibration, filter, alarm and config state to defaults
// a result waits in the output register while the next beat is taken; a second
// finished result is held aside and stalls req_ until the first one leaves
module accel_tilt_hysteresis_monitor #(
   parameter int MAX_CAL_SAMPLES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_mode,
   input  logic signed [15:0]  req_accel_x,
   input  logic signed [15:0]  req_accel_y,
   input  logic signed [15:0]  req_accel_z,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [16:0]  rsp_tilt_x,
   output logic signed [16:0]  rsp_tilt_y,
   output logic signed [16:0]  rsp_tilt_z,
   output logic signed [8:0]   rsp_whole_x,
   output logic signed [8:0]   rsp_whole_y,
   output logic signed [8:0]   rsp_whole_z,
   output logic                rsp_alarm_on,
   output logic                rsp_sensor_error,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_data
);
   import athm_pkg::*;

   logic [3:0] shift_ff;
   logic [7:0] on_ff, off_ff;
   logic       busy_ff, busy_in, go, fin, has_rsp, alarm;
   logic [2:0] ldone;
   angle_type  ang [3];
   angle_type  fx, fy, fz;
   logic       lane_start;
   logic       pend_ff;

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 4'd3; on_ff <= 8'd20; off_ff <= 8'd15;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_SHIFT: shift_ff <= csr_data[3:0];
            REG_ON:    on_ff <= csr_data;
            REG_OFF:   off_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // one item at a time; a held-aside result blocks the next beat
   logic out_busy;
   assign out_busy  = rsp_valid && rsp_stall;
   assign req_stall = busy_ff || pend_ff;
   assign go        = req_valid && !req_stall;
   assign lane_start = go && (req_mode == MODE_CAL || req_mode == MODE_MEAS);
   always_comb begin
      busy_in = busy_ff;
      if (go) busy_in = 1'b1;
      else if (fin) busy_in = 1'b0;
   end
   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   athm_lane u_lane_x (
      .clock, .reset, .start(lane_start), .axis_a(req_accel_x), .axis_b(req_accel_y),
      .axis_c(req_accel_z), .done(ldone[0]), .angle(ang[0]));
   athm_lane u_lane_y (
      .clock, .reset, .start(lane_start), .axis_a(req_accel_y), .axis_b(req_accel_x),
      .axis_c(req_accel_z), .done(ldone[1]), .angle(ang[1]));
   athm_lane u_lane_z (
      .clock, .reset, .start(lane_start), .axis_a(req_accel_z), .axis_b(req_accel_x),
      .axis_c(req_accel_y), .done(ldone[2]), .angle(ang[2]));

   athm_merge #(.MAX_CAL_SAMPLES(MAX_CAL_SAMPLES)) u_merge (
      .clock, .reset, .go, .mode(req_mode), .lanes_done(&ldone),
      .ang_x(ang[0]), .ang_y(ang[1]), .ang_z(ang[2]),
      .cfg_shift(shift_ff), .cfg_on(on_ff), .cfg_off(off_ff),
      .fin, .has_rsp, .filt_x(fx), .filt_y(fy), .filt_z(fz), .alarm);

   // result register; merge fin lasts one cycle, so hold it until output frees
   logic err_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= (fin && has_rsp && out_busy) || (pend_ff && out_busy);
      end
   end

   function automatic logic signed [8:0] whole_of(input angle_type v);
      logic [16:0] m;
      m = v < 0 ? 17'(-v) : 17'(v);
      m = m >> ANGLE_FRAC_BITS;
      return v < 0 ? -9'(m) : 9'(m);
   endfunction

   logic       rv_ff;
   angle_type  tx_ff, ty_ff, tz_ff;
   logic       al_ff;
   angle_type  hx_ff, hy_ff, hz_ff;
   logic       hal_ff, herr_ff;
   logic       u_merge_mode_err;
   logic [1:0] mode_hold_ff;
   // capture at fin into a hold register
   always_ff @(posedge clock) begin
      if (fin) begin
         herr_ff <= (u_merge_mode_err);
         hx_ff <= fx; hy_ff <= fy; hz_ff <= fz; hal_ff <= alarm;
      end
   end
   always_ff @(posedge clock) if (go) mode_hold_ff <= req_mode;
   assign u_merge_mode_err = (mode_hold_ff == MODE_ERR);

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (!out_busy) begin
         rv_ff <= (fin && has_rsp) || pend_ff;
      end
      if (!out_busy) begin
         if (fin) begin
            err_ff <= u_merge_mode_err;
            tx_ff <= u_merge_mode_err ? '0 : fx;
            ty_ff <= u_merge_mode_err ? '0 : fy;
            tz_ff <= u_merge_mode_err ? '0 : fz;
            al_ff <= u_merge_mode_err ? 1'b0 : alarm;
         end else if (pend_ff) begin
            err_ff <= herr_ff;
            tx_ff <= herr_ff ? '0 : hx_ff;
            ty_ff <= herr_ff ? '0 : hy_ff;
            tz_ff <= herr_ff ? '0 : hz_ff;
            al_ff <= herr_ff ? 1'b0 : hal_ff;
         end
      end
   end

   assign rsp_valid        = rv_ff;
   assign rsp_tilt_x       = tx_ff;
   assign rsp_tilt_y       = ty_ff;
   assign rsp_tilt_z       = tz_ff;
   assign rsp_whole_x      = whole_of(tx_ff);
   assign rsp_whole_y      = whole_of(ty_ff);
   assign rsp_whole_z      = whole_of(tz_ff);
   assign rsp_alarm_on     = al_ff;
   assign rsp_sensor_error = err_ff;
endmodule

FILE: tb/sv/tb.sv
// self-checking testbench for the accelerometer tilt monitor
module tb;
   import athm_pkg::*;

   typedef struct {
      logic signed [16:0] tilt [3];
      logic signed [8:0]  whole [3];
      logic               alarm;
      logic               err;
   } tilt_beat_t;

   typedef struct {
      logic [1:0]         mode;
      logic signed [15:0] x, y, z;
      bit                 typed;
      tilt_beat_t         res;
   } stim_row_t;

   // degree arctangent steps, times 2^16
   localparam longint ATAN_DEG [18] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
      58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};
   localparam string AXIS [3] = '{"x", "y", "z"};

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall;
   logic [1:0] req_mode = MODE_ERR;
   logic signed [15:0] req_accel_x = 0, req_accel_y = 0, req_accel_z = 0;
   logic rsp_valid, rsp_stall = 0;
   logic signed [16:0] rsp_tilt_x, rsp_tilt_y, rsp_tilt_z;
   logic signed [8:0] rsp_whole_x, rsp_whole_y, rsp_whole_z;
   logic rsp_alarm_on, rsp_sensor_error;
   logic csr_valid = 0, csr_ready;
   logic [1:0] csr_index = REG_SHIFT;
   logic [7:0] csr_data = 0;

   accel_tilt_hysteresis_monitor dut (.*);

   // model copy of state and registers
   int unsigned m_shift = 3, m_on = 20, m_off = 15;
   longint zero_ang [3], cal_sum [3], filt_ang [3];
   int unsigned cal_count;
   bit seeded, alarm_st;

   tilt_beat_t pending_tilts [$];
   int errors = 0;
   int items_sent = 0;
   int send_idle = 12, recv_idle = 81;
   bit recv_hold = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint unsigned isqrt(longint unsigned n);
      longint unsigned res = 0, b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint rnd_shift(longint v, int s);
      longint m;
      if (s == 0) return v;
      m = v < 0 ? -v : v;
      m = (m + (longint'(1) << (s - 1))) >>> s;
      return v < 0 ? -m : m;
   endfunction

   // cordic vectoring angle of a against the root of b^2 + c^2
   function automatic longint axis_angle(longint a, longint b, longint c);
      longint unsigned sq = longint'(b * b + c * c);
      longint x = longint'(isqrt(sq << 28));
      longint y = a * 16384;
      longint ang = 0, xs, ys, r;
      for (int i = 0; i < 18; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; ang += ATAN_DEG[i];
         end else if (y < 0) begin
            x -= ys; y += xs; ang -= ATAN_DEG[i];
         end
      end
      r = rnd_shift(ang, 8);
      if (r > 23040) r = 23040;
      if (r < -23040) r = -23040;
      return r;
   endfunction

   // advance the model by one beat; returns 1 with the beat it answers with
   function automatic bit tilt_predict(logic [1:0] mode, longint ax, longint ay, longint az,
                                       output tilt_beat_t res);
      longint ang [3], d, mx, a, mag, n;
      int unsigned s = m_shift > 8 ? 8 : m_shift;
      res = '{default: 0};
      ang[0] = axis_angle(ax, ay, az);
      ang[1] = axis_angle(ay, ax, az);
      ang[2] = axis_angle(az, ax, ay);
      case (mode)
         MODE_CAL: begin
            if (cal_count < 64) begin
               for (int i = 0; i < 3; i++) cal_sum[i] += ang[i];
               cal_count++;
            end
            return 0;
         end
         MODE_CLOSE: begin
            n = cal_count;
            for (int i = 0; i < 3; i++) begin
               if (n == 0) zero_ang[i] = 0;
               else begin
                  mag = cal_sum[i] < 0 ? -cal_sum[i] : cal_sum[i];
                  mag = (mag + n / 2) / n;
                  zero_ang[i] = cal_sum[i] < 0 ? -mag : mag;
               end
               cal_sum[i] = 0;
               filt_ang[i] = 0;
            end
            cal_count = 0;
            seeded = 0;
            alarm_st = 0;
            return 0;
         end
         MODE_ERR: begin
            res.err = 1;
            return 1;
         end
         default: begin
            mx = 0;
            for (int i = 0; i < 3; i++) begin
               d = ang[i] - zero_ang[i];
               if (d > 46080) d -= 92160;
               else if (d < -46080) d += 92160;
               if (seeded) filt_ang[i] += rnd_shift(d - filt_ang[i], s);
               else filt_ang[i] = d;
               a = filt_ang[i] < 0 ? -filt_ang[i] : filt_ang[i];
               if (a > mx) mx = a;
            end
            seeded = 1;
            if (!alarm_st && mx >= (longint'(m_on) << 8)) alarm_st = 1;
            else if (alarm_st && mx <= (longint'(m_off) << 8)) alarm_st = 0;
            for (int i = 0; i < 3; i++) begin
               a = (filt_ang[i] < 0 ? -filt_ang[i] : filt_ang[i]) >>> 8;
               res.tilt[i] = filt_ang[i][16:0];
               res.whole[i] = 9'(filt_ang[i] < 0 ? -a : a);
            end
            res.alarm = alarm_st;
            return 1;
         end
      endcase
   endfunction

   // offer one beat and hold it until taken
   task automatic send_beat(logic [1:0] mode, logic signed [15:0] x, y, z,
                            bit typed = 0, tilt_beat_t typed_res = '{default: 0});
      tilt_beat_t res;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_mode <= mode;
      req_accel_x <= x;
      req_accel_y <= y;
      req_accel_z <= z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (tilt_predict(mode, x, y, z, res))
         pending_tilts.push_back(typed ? typed_res : res);
   endtask

   // drain outstanding beats and let a close finish
   task automatic settle();
      req_valid <= 0;
      @(posedge clock);
      while (pending_tilts.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [7:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      case (idx)
         REG_SHIFT: m_shift = data[3:0];
         REG_ON:    m_on = data;
         default:   m_off = data;
      endcase
   endtask

   function automatic logic signed [15:0] rnd_axis();
      case ($urandom_range(5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 0;
         3: return $urandom_range(400) - 200;
         default: return $urandom;
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      tilt_beat_t want;
      logic signed [16:0] got_t [3];
      logic signed [8:0] got_w [3];
      if (!reset && rsp_valid && !rsp_stall) begin
         got_t = '{rsp_tilt_x, rsp_tilt_y, rsp_tilt_z};
         got_w = '{rsp_whole_x, rsp_whole_y, rsp_whole_z};
         if (pending_tilts.size() == 0) begin
            $error("unexpected result beat");
            errors++;
         end else begin
            want = pending_tilts.pop_front();
            for (int i = 0; i < 3; i++) begin
               if (got_t[i] !== want.tilt[i]) begin
                  $error("tilt_%s exp %0d got %0d", AXIS[i], want.tilt[i], got_t[i]);
                  errors++;
               end
               if (got_w[i] !== want.whole[i]) begin
                  $error("whole_%s exp %0d got %0d", AXIS[i], want.whole[i], got_w[i]);
                  errors++;
               end
            end
            if (rsp_alarm_on !== want.alarm) begin
               $error("alarm_on exp %0d got %0d", want.alarm, rsp_alarm_on);
               errors++;
            end
            if (rsp_sensor_error !== want.err) begin
               $error("sensor_error exp %0d got %0d", want.err, rsp_sensor_error);
               errors++;
            end
         end
      end
   end

   // receiver stall
   always @(posedge clock) begin
      rsp_stall <= recv_hold ? 1'b1 : ($urandom_range(99) < recv_idle);
   end

   // long receiver hold-off while the sender keeps offering
   initial begin
      wait (items_sent >= 300);
      @(posedge clock);
      recv_hold = 1;
      repeat (1500) @(posedge clock);
      recv_hold = 0;
   end

   initial begin
      #(12 * 3000000);
      $display("tb: FAIL");
      $finish;
   end

   // stimulus
   initial begin
      stim_row_t rows [$];
      tilt_beat_t zero_res, err_res;
      int ncal, nmeas;
      logic signed [15:0] bx, by, bz;
      zero_res = '{default: 0};
      err_res = '{default: 0};
      err_res.err = 1;
      rows = '{
         '{MODE_ERR,   16'sh7fff, 16'sh8000, 16'sh7fff, 1, err_res},
         '{MODE_MEAS,  0, 0, 0, 1, zero_res},
         '{MODE_MEAS,  16'sh7fff, 0, 0, 0, zero_res},
         '{MODE_MEAS,  16'sh8000, 0, 0, 0, zero_res},
         '{MODE_MEAS,  0, 16'sh7fff, 0, 0, zero_res},
         '{MODE_MEAS,  0, 0, 16'sh8000, 0, zero_res},
         '{MODE_MEAS,  16'sh8000, 16'sh8000, 16'sh8000, 0, zero_res},
         '{MODE_MEAS,  16'sh7fff, 16'sh7fff, 16'sh7fff, 0, zero_res},
         '{MODE_ERR,   0, 0, 0, 1, err_res},
         '{MODE_CLOSE, 0, 0, 0, 0, zero_res},
         '{MODE_MEAS,  100, -200, 16000, 0, zero_res},
         '{MODE_CAL,   16'sh7fff, 0, 0, 0, zero_res},
         '{MODE_CAL,   16'sh7fff, 1, -1, 0, zero_res},
         '{MODE_CAL,   16000, 300, 50, 0, zero_res},
         '{MODE_CLOSE, 5, 6, 7, 0, zero_res},
         '{MODE_MEAS,  16'sh8000, 0, 0, 0, zero_res},
         '{MODE_MEAS,  16'sh8000, 10, 10, 0, zero_res},
         '{MODE_ERR,   -1, -1, -1, 1, err_res},
         '{MODE_MEAS,  0, 16'sh7fff, 16'sh8000, 0, zero_res},
         '{MODE_CAL,   16'sh8000, 16'sh8000, 16'sh7fff, 0, zero_res},
         '{MODE_CAL,   0, 0, 0, 0, zero_res},
         '{MODE_CLOSE, 0, 0, 0, 0, zero_res},
         '{MODE_MEAS,  -5, 7, 16'sh7fff, 0, zero_res}
      };
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (rows[i])
         send_beat(rows[i].mode, rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].res);
      settle();
      csr_write(REG_SHIFT, 0);
      csr_write(REG_ON, 0);
      csr_write(REG_OFF, 0);

      // random sessions: calibrate, close, measure, with some noise
      while (items_sent < 1250) begin
         if (items_sent >= 450 && send_idle == 12) begin
            send_idle = 81;
            recv_idle = 12;
         end else if (items_sent >= 850 && send_idle == 81) begin
            send_idle = 0;
            recv_idle = 0;
         end
         if ($urandom_range(3) == 0) begin
            settle();
            case ($urandom_range(3))
               0: csr_write(REG_SHIFT, $urandom_range(1) ? 8 : 15);
               1: csr_write(REG_SHIFT, $urandom);
               default: csr_write(REG_SHIFT, $urandom_range(8));
            endcase
            case ($urandom_range(3))
               0: csr_write(REG_ON, $urandom_range(1) ? 180 : 255);
               1: csr_write(REG_ON, $urandom);
               default: csr_write(REG_ON, $urandom_range(60));
            endcase
            csr_write(REG_OFF, $urandom_range(4) == 0 ? $urandom : $urandom_range(40));
         end
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(12)) send_beat($urandom, rnd_axis(), rnd_axis(), rnd_axis());
         end else begin
            ncal = $urandom_range(9) == 0 ? $urandom_range(70, 62) : $urandom_range(6);
            bx = rnd_axis();
            by = rnd_axis();
            bz = rnd_axis();
            repeat (ncal)
               send_beat(MODE_CAL, bx + $signed($urandom_range(64)) - 32,
                         by + $signed($urandom_range(64)) - 32, bz);
            send_beat(MODE_CLOSE, $urandom, $urandom, $urandom);
            nmeas = $urandom_range(30, 4);
            for (int k = 0; k < nmeas; k++) begin
               if ($urandom_range(15) == 0) send_beat(MODE_ERR, $urandom, $urandom, $urandom);
               else if ($urandom_range(4) == 0) send_beat(MODE_MEAS, rnd_axis(), rnd_axis(),
                                                          rnd_axis());
               else send_beat(MODE_MEAS, bx + $signed($urandom_range(4000)) - 2000,
                              by + $signed($urandom_range(4000)) - 2000, bz);
            end
         end
         // sender pause until the block has drained
         if (items_sent >= 700 && items_sent < 760) begin
            req_valid <= 0;
            @(posedge clock);
            while (pending_tilts.size() != 0) @(posedge clock);
         end
      end

      req_valid <= 0;
      @(posedge clock);
      while (pending_tilts.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

FILE: accel_tilt_hysteresis_monitor.f
sv/athm_pkg.sv
sv/athm_lane.sv
sv/athm_merge.sv
sv/accel_tilt_hysteresis_monitor.sv
tb/sv/tb.sv
